FILE: rtl/lgcm_pkg.sv
`default_nettype none

package lgcm_pkg;

    // register map
    localparam int unsigned CFG_COUNT  = 6;
    localparam int unsigned APB_ADDR_W = 5;

    localparam logic [2:0] REG_LOW_RED    = 3'd0;
    localparam logic [2:0] REG_LOW_GREEN  = 3'd1;
    localparam logic [2:0] REG_LOW_BLUE   = 3'd2;
    localparam logic [2:0] REG_HIGH_RED   = 3'd3;
    localparam logic [2:0] REG_HIGH_GREEN = 3'd4;
    localparam logic [2:0] REG_HIGH_BLUE  = 3'd5;

    localparam logic [7:0] RST_LOW_RED    = 8'd255;
    localparam logic [7:0] RST_LOW_GREEN  = 8'd255;
    localparam logic [7:0] RST_LOW_BLUE   = 8'd255;
    localparam logic [7:0] RST_HIGH_RED   = 8'd0;
    localparam logic [7:0] RST_HIGH_GREEN = 8'd0;
    localparam logic [7:0] RST_HIGH_BLUE  = 8'd255;

    // colour channel positions
    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    // minimal-standard generator
    localparam logic [30:0] LEHMER_MOD  = 31'h7FFF_FFFF;
    localparam logic [15:0] LEHMER_MUL  = 16'd48271;
    localparam logic [30:0] LEHMER_SEED = 31'd1;

    // period in 1/255 ms: base plus step times the period byte
    localparam int unsigned PER_W       = 21;
    localparam logic [20:0] PERIOD_BASE = 21'd1211250;
    localparam logic [8:0]  PERIOD_STEP = 9'd500;

    // sine polynomial, Q30
    localparam logic [31:0] Q30_ONE = 32'h4000_0000;
    localparam logic [31:0] SIN_C1  = 32'd1686629713;
    localparam logic [31:0] SIN_C3  = 32'd693598669;
    localparam logic [31:0] SIN_C5  = 32'd85569306;
    localparam logic [31:0] SIN_C7  = 32'd5026995;
    localparam logic [31:0] SIN_C9  = 32'd172271;
    // Horner order: C7 first, C1 last
    localparam logic [3:0][31:0] SIN_HORNER = {SIN_C1, SIN_C3, SIN_C5, SIN_C7};

    // divider digit-pair counts
    localparam logic [5:0] DIV_PAIRS_TIME = 6'd32;
    localparam logic [5:0] DIV_PAIRS_MOD  = 6'd15;
    localparam logic [5:0] DIV_PAIRS_FRAC = 6'd16;

    typedef struct packed {
        logic [63:0]      time_ms;
        logic [7:0]       phase;
        logic [PER_W-1:0] period;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
    } t_job;

    typedef struct packed {
        logic             start;
        logic [PER_W-1:0] rem_init;
        logic [63:0]      dividend;
        logic [5:0]       pairs;
        logic [PER_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [31:0]      quotient;
        logic [PER_W-1:0] remainder;
    } t_div_rsp;

    typedef struct packed {
        logic [2:0][7:0] low;
        logic [2:0][7:0] high;
    } t_colours;

endpackage

`default_nettype wire

FILE: rtl/lgcm_queue.sv
`default_nettype none

module lgcm_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [AW:0]      r_count;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            // pointers wrap at the last entry, so any depth works
            if (push_ok) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (pop_ok) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (push_ok && !pop_ok) begin
                r_count <= r_count + (AW+1)'(1);
            end else if (pop_ok && !push_ok) begin
                r_count <= r_count - (AW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lgcm_front.sv
`default_nettype none

module lgcm_front
    import lgcm_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic        i_frame_start,
    input  wire logic [63:0] i_time_ms,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    output logic             o_job_push,
    output t_job             o_job,
    input  wire logic        i_job_full
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_RED  = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]  r_state;
    logic [30:0] r_lehmer;
    logic [46:0] r_prod;
    logic [15:0] r_draw;
    logic [63:0] r_time;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;

    logic [30:0] seed;
    logic [31:0] fold;
    logic [31:0] folded;

    // Mersenne fold: low 31 bits plus high part, one conditional subtract
    assign seed   = i_frame_start ? LEHMER_SEED : r_lehmer;
    assign fold   = {1'b0, r_prod[30:0]} + {16'd0, r_prod[46:31]};
    assign folded = (fold >= {1'b0, LEHMER_MOD}) ? fold - {1'b0, LEHMER_MOD} : fold;

    assign o_full     = (r_state != F_IDLE);
    assign o_job_push = (r_state == F_PUSH) && !i_job_full;

    always_comb begin
        o_job.time_ms = r_time;
        o_job.phase   = r_draw[7:0];
        o_job.period  = PERIOD_BASE + PER_W'(r_draw[15:8]) * PER_W'(PERIOD_STEP);
        o_job.red     = r_red;
        o_job.green   = r_green;
        o_job.blue    = r_blue;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= F_IDLE;
            r_lehmer <= LEHMER_SEED;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (i_push) begin
                        r_state <= F_RED;
                    end
                end
                F_RED: begin
                    r_lehmer <= folded[30:0];
                    r_state  <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_job_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && i_push) begin
            r_prod  <= 47'(seed) * 47'(LEHMER_MUL);
            r_time  <= i_time_ms;
            r_red   <= i_red;
            r_green <= i_green;
            r_blue  <= i_blue;
        end
        if (r_state == F_RED) begin
            r_draw <= folded[15:0];
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lgcm_div.sv
`default_nettype none

// Restoring divider, two quotient bits per cycle.
// Remainder must start below the divisor.
module lgcm_div
    import lgcm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [5:0]       r_cnt;
    logic [PER_W-1:0] r_rem;
    logic [PER_W-1:0] r_div;
    logic [63:0]      r_dvd;
    logic [31:0]      r_quo;

    logic [PER_W:0]   acc1;
    logic [PER_W:0]   acc2;
    logic [PER_W:0]   dif1;
    logic [PER_W:0]   dif2;
    logic             ge1;
    logic             ge2;
    logic [PER_W-1:0] rem1;
    logic [PER_W-1:0] rem2;

    always_comb begin
        acc1 = {r_rem, r_dvd[63]};
        dif1 = acc1 - {1'b0, r_div};
        ge1  = (acc1 >= {1'b0, r_div});
        rem1 = ge1 ? dif1[PER_W-1:0] : acc1[PER_W-1:0];
        acc2 = {rem1, r_dvd[62]};
        dif2 = acc2 - {1'b0, r_div};
        ge2  = (acc2 >= {1'b0, r_div});
        rem2 = ge2 ? dif2[PER_W-1:0] : acc2[PER_W-1:0];
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.pairs;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem_init;
            r_div <= i_req.divisor;
            r_dvd <= i_req.dividend;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= rem2;
            r_dvd <= {r_dvd[61:0], 2'b00};
            r_quo <= {r_quo[29:0], ge1, ge2};
        end
    end

endmodule

`default_nettype wire

FILE: rtl/lgcm_back.sv
`default_nettype none

module lgcm_back
    import lgcm_pkg::*;
#(
    parameter int unsigned TABLE_ENTRIES = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_q_empty,
    input  wire t_job     i_q_job,
    output logic          o_q_pop,
    output t_div_req      o_div_req,
    input  wire t_div_rsp i_div_rsp,
    input  wire t_colours i_colours,
    output logic          o_empty,
    input  wire logic     i_pop,
    output logic [7:0]    o_red,
    output logic [7:0]    o_green,
    output logic [7:0]    o_blue
);

    localparam logic [31:0]      N_WORD = 32'(TABLE_ENTRIES);
    localparam logic [PER_W-1:0] N_DIV  = PER_W'(TABLE_ENTRIES);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_TMOD = 5'd1;
    localparam logic [4:0] S_MMOD = 5'd2;
    localparam logic [4:0] S_FRAC = 5'd3;
    localparam logic [4:0] S_IDX  = 5'd4;
    localparam logic [4:0] S_PT   = 5'd5;
    localparam logic [4:0] S_PTW  = 5'd6;
    localparam logic [4:0] S_Y2   = 5'd7;
    localparam logic [4:0] S_Y2R  = 5'd8;
    localparam logic [4:0] S_MUL  = 5'd9;
    localparam logic [4:0] S_SUB  = 5'd10;
    localparam logic [4:0] S_YT   = 5'd11;
    localparam logic [4:0] S_SINE = 5'd12;
    localparam logic [4:0] S_LO   = 5'd13;
    localparam logic [4:0] S_HI   = 5'd14;
    localparam logic [4:0] S_LVL  = 5'd15;
    localparam logic [4:0] S_SC   = 5'd16;
    localparam logic [4:0] S_DIV  = 5'd17;
    localparam logic [4:0] S_OUT  = 5'd18;

    // phase byte in Q0.32 turns: floor(p * 2^32 / 255)
    function automatic logic [31:0] phase_turns(input logic [7:0] p);
        return {p, p, p, p} + {31'd0, (p == 8'hFF)};
    endfunction

    logic [4:0]      r_state;
    logic [4:0]      n_state;
    t_job            r_job;
    logic [31:0]     r_ang;
    logic [30:0]     r_y;
    logic            r_neg;
    logic [30:0]     r_y2;
    logic [31:0]     r_t;
    logic [1:0]      r_k;
    logic [16:0]     r_x;
    logic [23:0]     r_acc;
    logic [23:0]     r_lvl;
    logic [1:0]      r_ch;
    logic [2:0][7:0] r_res;
    logic [63:0]     r_prod;
    logic [2:0][7:0] r_out;
    logic            r_out_valid;

    logic [31:0] m_a;
    logic [31:0] m_b;
    logic [29:0] scaled;
    logic [30:0] y_next;
    logic [31:0] sine_raw;
    logic [31:0] sine_mag;
    logic [31:0] half;
    logic [16:0] inv_x;
    logic [7:0]  chan_in;
    logic [15:0] lvl_hi;
    logic [16:0] div255;
    logic        out_load;

    always_comb begin
        scaled   = {1'b0, i_div_rsp.remainder, 8'd0} - {9'd0, i_div_rsp.remainder};
        y_next   = i_div_rsp.quotient[30]
                 ? (31'h4000_0000 - {1'b0, i_div_rsp.quotient[29:0]})
                 : {1'b0, i_div_rsp.quotient[29:0]};
        sine_raw = r_prod[61:30];
        sine_mag = (sine_raw > Q30_ONE) ? Q30_ONE : sine_raw;
        half     = r_neg ? (Q30_ONE - sine_mag) : (Q30_ONE + sine_mag);
        inv_x    = 17'h1_0000 - r_x;
        lvl_hi   = r_prod[31:16];
        // exact floor(v / 255) for 16-bit v up to 65534
        div255   = 17'(lvl_hi) + 17'd1 + 17'(lvl_hi[15:8]);
        case (r_ch)
            CH_RED:   chan_in = r_job.red;
            CH_GREEN: chan_in = r_job.green;
            default:  chan_in = r_job.blue;
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        case (r_state)
            S_IDX: begin
                m_a = r_ang;
                m_b = N_WORD;
            end
            S_Y2: begin
                m_a = {1'b0, r_y};
                m_b = {1'b0, r_y};
            end
            S_MUL: begin
                m_a = {1'b0, r_y2};
                m_b = r_t;
            end
            S_YT: begin
                m_a = {1'b0, r_y};
                m_b = r_t;
            end
            S_LO: begin
                m_a = 32'(i_colours.low[r_ch]);
                m_b = 32'(inv_x);
            end
            S_HI: begin
                m_a = 32'(i_colours.high[r_ch]);
                m_b = 32'(r_x);
            end
            S_SC: begin
                m_a = 32'(chan_in);
                m_b = 32'(r_lvl);
            end
            default: begin
                m_a = '0;
                m_b = '0;
            end
        endcase
    end

    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_pop);

    always_comb begin
        n_state            = r_state;
        o_q_pop            = 1'b0;
        o_div_req.start    = 1'b0;
        o_div_req.rem_init = '0;
        o_div_req.dividend = '0;
        o_div_req.pairs    = DIV_PAIRS_FRAC;
        o_div_req.divisor  = r_job.period;
        case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop            = 1'b1;
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = i_q_job.time_ms;
                    o_div_req.pairs    = DIV_PAIRS_TIME;
                    o_div_req.divisor  = i_q_job.period;
                    n_state            = S_TMOD;
                end
            end
            S_TMOD: begin
                if (i_div_rsp.done) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.dividend = {scaled, 34'd0};
                    o_div_req.pairs    = DIV_PAIRS_MOD;
                    n_state            = S_MMOD;
                end
            end
            S_MMOD: begin
                if (i_div_rsp.done) begin
                    o_div_req.start    = 1'b1;
                    o_div_req.rem_init = i_div_rsp.remainder;
                    n_state            = S_FRAC;
                end
            end
            S_FRAC: begin
                if (i_div_rsp.done) begin
                    n_state = S_IDX;
                end
            end
            S_IDX: begin
                n_state = S_PT;
            end
            S_PT: begin
                o_div_req.start    = 1'b1;
                o_div_req.rem_init = r_prod[PER_W+31:32];
                o_div_req.divisor  = N_DIV;
                n_state            = S_PTW;
            end
            S_PTW: begin
                if (i_div_rsp.done) begin
                    n_state = S_Y2;
                end
            end
            S_Y2:   n_state = S_Y2R;
            S_Y2R:  n_state = S_MUL;
            S_MUL:  n_state = S_SUB;
            S_SUB:  n_state = (r_k == 2'd3) ? S_YT : S_MUL;
            S_YT:   n_state = S_SINE;
            S_SINE: n_state = S_LO;
            S_LO:   n_state = S_HI;
            S_HI:   n_state = S_LVL;
            S_LVL:  n_state = S_SC;
            S_SC:   n_state = S_DIV;
            S_DIV:  n_state = (r_ch == CH_BLUE) ? S_OUT : S_LO;
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_k         <= '0;
            r_ch        <= '0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_Y2R) begin
                r_k <= '0;
            end else if (r_state == S_SUB) begin
                r_k <= r_k + 2'd1;
            end
            if (r_state == S_SINE) begin
                r_ch <= CH_RED;
            end else if (r_state == S_DIV) begin
                r_ch <= r_ch + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
        if (r_state == S_IDLE && !i_q_empty) begin
            r_job <= i_q_job;
        end
        if (r_state == S_FRAC && i_div_rsp.done) begin
            r_ang <= i_div_rsp.quotient + phase_turns(r_job.phase);
        end
        if (r_state == S_PTW && i_div_rsp.done) begin
            r_neg <= i_div_rsp.quotient[31];
            r_y   <= y_next;
        end
        if (r_state == S_Y2R) begin
            r_y2 <= r_prod[60:30];
            r_t  <= SIN_C9;
        end
        if (r_state == S_SUB) begin
            r_t <= SIN_HORNER[r_k] - r_prod[61:30];
        end
        if (r_state == S_SINE) begin
            r_x <= half[31:15];
        end
        if (r_state == S_HI) begin
            r_acc <= r_prod[23:0];
        end
        if (r_state == S_LVL) begin
            r_lvl <= r_acc + r_prod[23:0];
        end
        if (r_state == S_DIV) begin
            r_res[r_ch] <= div255[15:8];
        end
        if (out_load) begin
            r_out <= r_res;
        end
    end

    assign o_empty = !r_out_valid;
    assign o_red   = r_out[CH_RED];
    assign o_green = r_out[CH_GREEN];
    assign o_blue  = r_out[CH_BLUE];

endmodule

`default_nettype wire

FILE: rtl/led_glow_color_modulator.sv
// LED glow colour modulator.
// Input queue side: one transaction per LED (frame_start, time_ms, RGB), taken on
// push while full is low. The front stage draws the LED's generator value (one
// multiply and a Mersenne fold) and hands phase and period to a short job queue.
// Result queue side: while empty is low the scaled RGB bytes are on o_*_out; pop
// takes them. One result transaction per input transaction, in order.
// The back end takes one LED at a time; its pace is set by the shared restoring
// divider (2 bits a cycle: 32 + 15 + 16 + 16 steps for time mod period, the 255x
// fold, the angle fraction and the table point) and its single shared multiplier
// (sine polynomial by Horner, then two lerp products and one scale per channel).
// A stalled receiver holds the result register; the back end then waits with the
// next result ready, the job queue fills, and finally full rises on the input.
// Reset (synchronous, active low) empties both queues, restarts the generator at
// one and loads the default glow colours. Colour registers sit on an APB port,
// bytes at 4*i, write only while idle.
`default_nettype none

module led_glow_color_modulator
    import lgcm_pkg::*;
#(
    parameter int unsigned SINE_TABLE_ENTRIES = 1024,
    parameter int unsigned QUEUE_DEPTH        = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [31:0]           pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    // input transactions
    input  wire logic                  push,
    output logic                       full,
    input  wire logic                  i_frame_start,
    input  wire logic [63:0]           i_time_ms,
    input  wire logic [7:0]            i_red_in,
    input  wire logic [7:0]            i_green_in,
    input  wire logic [7:0]            i_blue_in,
    // result transactions
    output logic                       empty,
    input  wire logic                  pop,
    output logic [7:0]                 o_red_out,
    output logic [7:0]                 o_green_out,
    output logic [7:0]                 o_blue_out
);

    t_colours  r_colours;
    logic      cfg_write;
    logic [2:0] cfg_index;

    logic      job_push;
    t_job      job_in;
    logic      job_full;
    logic      job_pop;
    logic      job_empty;
    t_job      job_head;

    t_div_req  div_req;
    t_div_rsp  div_rsp;

    // ---------------- configuration registers ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colours.low[CH_RED]    <= RST_LOW_RED;
            r_colours.low[CH_GREEN]  <= RST_LOW_GREEN;
            r_colours.low[CH_BLUE]   <= RST_LOW_BLUE;
            r_colours.high[CH_RED]   <= RST_HIGH_RED;
            r_colours.high[CH_GREEN] <= RST_HIGH_GREEN;
            r_colours.high[CH_BLUE]  <= RST_HIGH_BLUE;
        end else if (cfg_write) begin
            // addresses past the last register are dropped
            case (cfg_index)
                REG_LOW_RED:    r_colours.low[CH_RED]    <= pwdata[7:0];
                REG_LOW_GREEN:  r_colours.low[CH_GREEN]  <= pwdata[7:0];
                REG_LOW_BLUE:   r_colours.low[CH_BLUE]   <= pwdata[7:0];
                REG_HIGH_RED:   r_colours.high[CH_RED]   <= pwdata[7:0];
                REG_HIGH_GREEN: r_colours.high[CH_GREEN] <= pwdata[7:0];
                REG_HIGH_BLUE:  r_colours.high[CH_BLUE]  <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_LOW_RED:    prdata = {24'd0, r_colours.low[CH_RED]};
            REG_LOW_GREEN:  prdata = {24'd0, r_colours.low[CH_GREEN]};
            REG_LOW_BLUE:   prdata = {24'd0, r_colours.low[CH_BLUE]};
            REG_HIGH_RED:   prdata = {24'd0, r_colours.high[CH_RED]};
            REG_HIGH_GREEN: prdata = {24'd0, r_colours.high[CH_GREEN]};
            REG_HIGH_BLUE:  prdata = {24'd0, r_colours.high[CH_BLUE]};
            default:        prdata = '0;
        endcase
    end

    // ---------------- front: accept, draw phase and period ----------------
    lgcm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .o_full        (full),
        .i_frame_start (i_frame_start),
        .i_time_ms     (i_time_ms),
        .i_red         (i_red_in),
        .i_green       (i_green_in),
        .i_blue        (i_blue_in),
        .o_job_push    (job_push),
        .o_job         (job_in),
        .i_job_full    (job_full)
    );

    // ---------------- job queue between front and back ----------------
    lgcm_queue #(
        .WIDTH ($bits(t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_head),
        .o_empty (job_empty)
    );

    // ---------------- back: angle, sine, colour scaling ----------------
    lgcm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    lgcm_back #(
        .TABLE_ENTRIES (SINE_TABLE_ENTRIES)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (job_empty),
        .i_q_job   (job_head),
        .o_q_pop   (job_pop),
        .o_div_req (div_req),
        .i_div_rsp (div_rsp),
        .i_colours (r_colours),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_red     (o_red_out),
        .o_green   (o_green_out),
        .o_blue    (o_blue_out)
    );

endmodule

`default_nettype wire

FILE: test/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the LED glow colour modulator.
// One LED per input transaction; one scaled RGB result per transaction, in order.
// A local predictor (generator, period, angle, sine weight, colour lerp) works out
// each result once the block has taken its LED; results are checked field by field as popped.
module tb_top;
    import lgcm_pkg::*;

    localparam int unsigned TABLE_ENTRIES = 1024;
    localparam int unsigned QUARTER       = TABLE_ENTRIES / 4;
    localparam int unsigned GAP_MAX       = 14;
    localparam int unsigned N_PHASES      = 5;
    localparam int unsigned PHASE_ITEMS   = 250;
    localparam int unsigned TAIL_CYCLES   = 200;     // a little over one LED's latency
    localparam int unsigned CYCLE_LIMIT   = 1000000; // several times the slowest run

    // predictor constants
    localparam logic [63:0] PRNG_MOD = 64'd2147483647;
    localparam logic [63:0] PRNG_MUL = 64'd48271;
    localparam logic [63:0] PER_BASE = 64'd1211250; // 5000 ms - 250 ms, in 1/255 ms
    localparam logic [63:0] PER_STEP = 64'd500;
    localparam logic [63:0] ONE_Q30  = 64'h4000_0000;
    localparam logic [63:0] K1       = 64'd1686629713;
    localparam logic [63:0] K3       = 64'd693598669;
    localparam logic [63:0] K5       = 64'd85569306;
    localparam logic [63:0] K7       = 64'd5026995;
    localparam logic [63:0] K9       = 64'd172271;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // directed rows: plain LED, LED aimed at a sine table point, register write
    typedef enum logic [1:0] {ROW_LED, ROW_AIM, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic        fs;
        logic [63:0] arg;    // time_ms, table index or register index
        logic [31:0] data;   // pwdata for register rows
        t_rgb        pix;
        logic        typed;  // expectation typed in below rather than predicted
        t_rgb        want;
    } t_stim_row;

    // DUT signals, the inputs all known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  psel          = 1'b0;
    logic                  penable       = 1'b0;
    logic                  pwrite        = 1'b0;
    logic [APB_ADDR_W-1:0] paddr         = '0;
    logic [31:0]           pwdata        = '0;
    logic [31:0]           prdata;
    logic                  pready;
    logic                  push          = 1'b0;
    logic                  full;
    logic                  i_frame_start = 1'b0;
    logic [63:0]           i_time_ms     = '0;
    logic [7:0]            i_red_in      = '0;
    logic [7:0]            i_green_in    = '0;
    logic [7:0]            i_blue_in     = '0;
    logic                  empty;
    logic                  pop           = 1'b0;
    logic [7:0]            o_red_out;
    logic [7:0]            o_green_out;
    logic [7:0]            o_blue_out;

    // predictor state and colour registers as the block should hold them
    logic [30:0] draw_state;
    logic [7:0]  colour_reg [CFG_COUNT];

    t_rgb        pending_rgb [$];   // expected results, oldest first
    t_stim_row   stim_rows [$];
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    logic        sender_burst   = 1'b0;
    logic        receiver_burst = 1'b0;

    led_glow_color_modulator #(
        .SINE_TABLE_ENTRIES(TABLE_ENTRIES)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .push          (push),
        .full          (full),
        .i_frame_start (i_frame_start),
        .i_time_ms     (i_time_ms),
        .i_red_in      (i_red_in),
        .i_green_in    (i_green_in),
        .i_blue_in     (i_blue_in),
        .empty         (empty),
        .pop           (pop),
        .o_red_out     (o_red_out),
        .o_green_out   (o_green_out),
        .o_blue_out    (o_blue_out)
    );

    always #2 i_clk = ~i_clk;

    // hard stop in case the block hangs
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $error("timeout after %0d cycles, %0d results outstanding",
                   cycle_count, pending_rgb.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------- predictor

    // minimal-standard generator step
    function automatic logic [30:0] draw_after(input logic [30:0] cur);
        logic [63:0] prod;
        prod = 64'(cur) * PRNG_MUL;
        return 31'(prod % PRNG_MOD);
    endfunction

    // draw the next LED would get, without advancing the generator
    function automatic logic [30:0] peek_draw(input logic fs);
        return draw_after(fs ? 31'd1 : draw_state);
    endfunction

    // period in 1/255 ms from the draw's second byte
    function automatic logic [63:0] period_of(input logic [30:0] r);
        return PER_BASE + PER_STEP * 64'(r[15:8]);
    endfunction

    // (sin + 1) / 2 at Q0.32 turns, Q0.16 result up to 65536 inclusive
    function automatic logic [16:0] glow_weight(input logic [31:0] a);
        logic [63:0] y, y2, t;
        y = 64'(a[29:0]);
        if (a[30]) begin
            y = ONE_Q30 - y;     // mirror in second and fourth quadrants
        end
        y2 = (y * y) >> 30;
        t  = K7 - ((y2 * K9) >> 30);
        t  = K5 - ((y2 * t) >> 30);
        t  = K3 - ((y2 * t) >> 30);
        t  = K1 - ((y2 * t) >> 30);
        t  = (y * t) >> 30;
        if (t > ONE_Q30) begin
            t = ONE_Q30;
        end
        if (a[31]) begin
            return 17'((ONE_Q30 - t) >> 15);
        end
        return 17'((ONE_Q30 + t) >> 15);
    endfunction

    // in * lerp(lo, hi, x) / 255, truncated
    function automatic logic [7:0] scale_byte(input logic [7:0] pin, input logic [7:0] lo,
                                              input logic [7:0] hi, input logic [16:0] x);
        logic [63:0] level;
        level = 64'(lo) * (64'd65536 - 64'(x)) + 64'(hi) * 64'(x);
        return 8'((64'(pin) * level) / (64'd255 * 64'd65536));
    endfunction

    // result of one accepted LED; advances the generator
    function automatic t_rgb glow_predict(input logic fs, input logic [63:0] tms,
                                          input t_rgb pix);
        logic [30:0] r;
        logic [63:0] per, m, ang, idx, pt;
        logic [16:0] x;
        t_rgb        res;
        r          = peek_draw(fs);
        draw_state = r;
        per        = period_of(r);
        m          = ((tms % per) * 64'd255) % per;
        ang        = ((m << 32) / per + (64'(r[7:0]) << 32) / 64'd255) & 64'hFFFF_FFFF;
        idx        = (ang * 64'(TABLE_ENTRIES)) >> 32;
        pt         = ((idx << 32) / 64'(TABLE_ENTRIES)) & 64'hFFFF_FFFF;
        x          = glow_weight(pt[31:0]);
        res.red    = scale_byte(pix.red, colour_reg[REG_LOW_RED], colour_reg[REG_HIGH_RED], x);
        res.green  = scale_byte(pix.green, colour_reg[REG_LOW_GREEN],
                                colour_reg[REG_HIGH_GREEN], x);
        res.blue   = scale_byte(pix.blue, colour_reg[REG_LOW_BLUE],
                                colour_reg[REG_HIGH_BLUE], x);
        return res;
    endfunction

    // time_ms that lands the next LED mid-way into sine table point 'target'.
    // Below period/255, time maps to 255*t, so the angle moves in fine steps.
    function automatic logic [63:0] aim_time(input logic fs, input int unsigned target);
        logic [30:0] r;
        logic [63:0] per, want, f, mc, t;
        r    = peek_draw(fs);
        per  = period_of(r);
        want = ((64'(target) * 2 + 1) << 32) / (64'(TABLE_ENTRIES) * 2);
        f    = (want - (64'(r[7:0]) << 32) / 64'd255) & 64'hFFFF_FFFF;
        mc   = (f * per) >> 32;
        t    = (mc + 64'd127) / 64'd255;
        return t + per * 64'($urandom);   // whole periods on top vary the upper bits
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    // bytes weighted towards the extremes
    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: begin
                return 8'h00;
            end
            1: begin
                return 8'hFF;
            end
            default: begin
                return 8'($urandom);
            end
        endcase
    endfunction

    // table points, a third of them on or next to quadrant edges
    function automatic int unsigned pick_index();
        if ($urandom_range(0, 2) != 0) begin
            return $urandom_range(0, TABLE_ENTRIES - 1);
        end
        case ($urandom_range(0, 7))
            0: begin
                return 0;
            end
            1: begin
                return QUARTER - 1;
            end
            2: begin
                return QUARTER;          // full weight
            end
            3: begin
                return QUARTER + 1;
            end
            4: begin
                return 2 * QUARTER;
            end
            5: begin
                return 3 * QUARTER;      // zero weight
            end
            6: begin
                return 2 * QUARTER - 1;
            end
            default: begin
                return TABLE_ENTRIES - 1;
            end
        endcase
    endfunction

    task automatic add_row(input t_row_kind kind, input logic fs, input logic [63:0] arg,
                           input logic [31:0] data, input t_rgb pix, input logic typed,
                           input t_rgb want);
        t_stim_row row;
        row.kind  = kind;
        row.fs    = fs;
        row.arg   = arg;
        row.data  = data;
        row.pix   = pix;
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    // one input transaction; the expectation is queued once full is low again after the push
    task automatic send_led(input logic fs, input logic [63:0] tms, input t_rgb pix,
                            input logic typed, input t_rgb want);
        int unsigned gap;
        t_rgb        guess;
        if ($urandom_range(0, 39) == 0) begin
            sender_burst = !sender_burst;
        end
        gap = sender_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push          <= 1'b1;
        i_frame_start <= fs;
        i_time_ms     <= tms;
        i_red_in      <= pix.red;
        i_green_in    <= pix.green;
        i_blue_in     <= pix.blue;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        guess = glow_predict(fs, tms, pix);
        pending_rgb.push_back(typed ? want : guess);
    endtask

    // hold off the sender until every outstanding result has been popped
    task automatic drain_results();
        push <= 1'b0;
        while (pending_rgb.size() != 0) @(posedge i_clk);
    endtask

    // one APB transfer: setup, access, completes on pready
    task automatic apb_cycle(input logic wr, input logic [2:0] idx, input logic [31:0] data,
                             output logic [31:0] rd);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // write one register; indexes past the map must leave everything alone
    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] data);
        logic [31:0] unused;
        apb_cycle(1'b1, idx, data, unused);
        if (idx < CFG_COUNT) begin
            colour_reg[idx] = data[7:0];
        end
    endtask

    task automatic check_colours();
        logic [31:0] rd;
        int          i;
        for (i = 0; i < CFG_COUNT; i++) begin
            apb_cycle(1'b0, 3'(i), 32'd0, rd);
            if (rd !== {24'd0, colour_reg[i]}) begin
                $error("prdata of register %0d: expected %0d, got %0d", i, colour_reg[i], rd);
                fail_count++;
            end
        end
    endtask

    task automatic check_byte(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    // ---------------------------------------------------------------- result side

    // receiver: random stall before each pop, with stall-free stretches
    initial begin
        int unsigned stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if ($urandom_range(0, 39) == 0) begin
                receiver_burst = !receiver_burst;
            end
            stall = receiver_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (stall != 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
        end
    end

    // every popped result against the oldest expectation
    always @(posedge i_clk) begin : result_check
        t_rgb want;
        if (i_rst_n && pop && !empty) begin
            if (pending_rgb.size() == 0) begin
                $error("result transaction with none outstanding: %0d %0d %0d",
                       o_red_out, o_green_out, o_blue_out);
                fail_count++;
            end else begin
                want = pending_rgb.pop_front();
                check_byte("red_out", want.red, o_red_out);
                check_byte("green_out", want.green, o_green_out);
                check_byte("blue_out", want.blue, o_blue_out);
            end
        end
    end

    // ---------------------------------------------------------------- main sequence

    initial begin
        t_stim_row   row;
        int unsigned ph, i, sent, flen, led, mode;
        logic        fs;
        logic [63:0] ftime, tms, wall_ms;
        logic [7:0]  lvl;

        // model at reset: generator at one, default glow colours
        draw_state                 = 31'd1;
        colour_reg[REG_LOW_RED]    = 8'd255;
        colour_reg[REG_LOW_GREEN]  = 8'd255;
        colour_reg[REG_LOW_BLUE]   = 8'd255;
        colour_reg[REG_HIGH_RED]   = 8'd0;
        colour_reg[REG_HIGH_GREEN] = 8'd0;
        colour_reg[REG_HIGH_BLUE]  = 8'd255;

        // Directed rows. Default colours first: blue has equal ends so passes straight
        // through; quarter points give full weight (second colour) and zero weight.
        add_row(ROW_LED, 1'b1, 64'd0, 32'd0, 24'h000000, 1'b1, 24'h000000);
        add_row(ROW_LED, 1'b0, '1, 32'd0, 24'h0000FF, 1'b1, 24'h0000FF);
        add_row(ROW_LED, 1'b0, '1, 32'd0, 24'hFFFFFF, 1'b0, 24'd0);
        add_row(ROW_LED, 1'b0, 64'h8000_0000_0000_0000, 32'd0, 24'h808080, 1'b0, 24'd0);
        add_row(ROW_LED, 1'b1, 64'h5555_5555_5555_5555, 32'd0, 24'h55AA01, 1'b0, 24'd0);
        add_row(ROW_LED, 1'b0, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0, 24'hAA55FE, 1'b0, 24'd0);
        add_row(ROW_AIM, 1'b1, 64'(0), 32'd0, 24'hFFFFFF, 1'b0, 24'd0);
        add_row(ROW_AIM, 1'b0, 64'(QUARTER), 32'd0, 24'hFFFFFF, 1'b1, 24'h0000FF);
        add_row(ROW_AIM, 1'b0, 64'(2 * QUARTER), 32'd0, 24'hFFFFFF, 1'b0, 24'd0);
        add_row(ROW_AIM, 1'b0, 64'(3 * QUARTER), 32'd0, 24'hFFFFFF, 1'b1, 24'hFFFFFF);
        add_row(ROW_AIM, 1'b0, 64'(TABLE_ENTRIES - 1), 32'd0, 24'hA55A3C, 1'b0, 24'd0);
        add_row(ROW_AIM, 1'b0, 64'(QUARTER - 1), 32'd0, 24'h0180FE, 1'b0, 24'd0);
        add_row(ROW_AIM, 1'b0, 64'(QUARTER + 1), 32'd0, 24'hFF7F00, 1'b0, 24'd0);
        // both colours white, junk in the upper pwdata bits: output equals input
        for (i = 0; i < CFG_COUNT; i++) begin
            add_row(ROW_REG, 1'b0, 64'(i), 32'hA5A5_A5FF, 24'd0, 1'b0, 24'd0);
        end
        add_row(ROW_REG, 1'b0, 64'(CFG_COUNT), 32'h0000_0000, 24'd0, 1'b0, 24'd0);
        add_row(ROW_LED, 1'b1, 64'd123456789, 32'd0, 24'h123456, 1'b1, 24'h123456);
        add_row(ROW_AIM, 1'b0, 64'(QUARTER), 32'd0, 24'h07C8FF, 1'b1, 24'h07C8FF);
        add_row(ROW_AIM, 1'b0, 64'(3 * QUARTER), 32'd0, 24'hFE0180, 1'b1, 24'hFE0180);
        // both colours black: output always zero
        for (i = 0; i < CFG_COUNT; i++) begin
            add_row(ROW_REG, 1'b0, 64'(i), 32'h5A5A_5A00, 24'd0, 1'b0, 24'd0);
        end
        add_row(ROW_REG, 1'b0, 64'(CFG_COUNT + 1), 32'h0000_00FF, 24'd0, 1'b0, 24'd0);
        add_row(ROW_LED, 1'b0, '1, 32'd0, 24'hFFFFFF, 1'b1, 24'h000000);
        add_row(ROW_AIM, 1'b1, 64'(QUARTER), 32'd0, 24'hFFFFFF, 1'b1, 24'h000000);
        // black to white
        for (i = 0; i < CFG_COUNT; i++) begin
            add_row(ROW_REG, 1'b0, 64'(i), (i < REG_HIGH_RED) ? 32'hFFFF_FF00 : 32'h0000_00FF,
                    24'd0, 1'b0, 24'd0);
        end
        add_row(ROW_AIM, 1'b0, 64'(QUARTER), 32'd0, 24'hFFFFFF, 1'b1, 24'hFFFFFF);
        add_row(ROW_AIM, 1'b0, 64'(3 * QUARTER), 32'd0, 24'hFFFFFF, 1'b1, 24'h000000);
        add_row(ROW_AIM, 1'b0, 64'(0), 32'd0, 24'hFF8001, 1'b0, 24'd0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            row = stim_rows[k];
            case (row.kind)
                ROW_REG: begin
                    drain_results();
                    cfg_write(row.arg[2:0], row.data);
                    check_colours();
                end
                ROW_AIM: begin
                    send_led(row.fs, aim_time(row.fs, row.arg[31:0]), row.pix, row.typed,
                             row.want);
                end
                default: begin
                    send_led(row.fs, row.arg, row.pix, row.typed, row.want);
                end
            endcase
        end

        // Random phases, each under its own colour pair: random, black to white,
        // white to black, then random again. Mostly whole frames (reseed on the
        // first LED, one timestamp), with stray reseeds, missing reseeds and odd times.
        wall_ms = 64'($urandom);
        for (ph = 0; ph < N_PHASES; ph++) begin
            drain_results();
            for (i = 0; i < CFG_COUNT; i++) begin
                case (ph)
                    1: begin
                        lvl = (i < REG_HIGH_RED) ? 8'h00 : 8'hFF;
                    end
                    2: begin
                        lvl = (i < REG_HIGH_RED) ? 8'hFF : 8'h00;
                    end
                    default: begin
                        lvl = rand_byte();
                    end
                endcase
                cfg_write(3'(i), {24'($urandom), lvl});
            end
            if ($urandom_range(0, 1) == 0) begin
                cfg_write(3'(CFG_COUNT + $urandom_range(0, 1)), $urandom);
            end
            check_colours();

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                flen    = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 24);
                mode    = $urandom_range(0, 9);
                wall_ms = wall_ms + 64'($urandom_range(1, 40));
                case (mode)
                    0, 1, 2, 3: begin
                        ftime = wall_ms;
                    end
                    4, 5: begin
                        ftime = {$urandom, $urandom};
                    end
                    default: begin
                        ftime = 64'($urandom_range(0, 3000000));
                    end
                endcase
                for (led = 0; led < flen && sent < PHASE_ITEMS; led++) begin
                    fs = (led == 0) ? ($urandom_range(0, 19) != 0)
                                    : ($urandom_range(0, 59) == 0);
                    if (mode >= 8) begin
                        tms = aim_time(fs, pick_index());
                    end else if ($urandom_range(0, 29) == 0) begin
                        tms = {$urandom, $urandom};
                    end else begin
                        tms = ftime;
                    end
                    send_led(fs, tms, {rand_byte(), rand_byte(), rand_byte()}, 1'b0, 24'd0);
                    sent++;
                    // now and then let the block run completely dry
                    if ($urandom_range(0, 149) == 0) begin
                        drain_results();
                    end
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lgcm_pkg.sv
rtl/lgcm_queue.sv
rtl/lgcm_front.sv
rtl/lgcm_div.sv
rtl/lgcm_back.sv
rtl/led_glow_color_modulator.sv
test/tb_top.sv
